/* sv/mie_pkg.sv */
`default_nettype none

package mie_pkg;

  localparam int MIE_WIDTH = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_NEXT,
    ST_FINAL
  } mie_state_t;

  typedef struct packed {
    logic fits;  // divisor doubled still fits under the dividend
    logic ge;    // divisor fits under the dividend
  } mie_flags_t;

endpackage

`default_nettype wire

/* sv/mie_unit.sv */
`default_nettype none

module mie_unit
  import mie_pkg::*;
#(
  parameter int WIDTH = MIE_WIDTH
) (
  input  wire logic [WIDTH-1:0] rp,
  input  wire logic [WIDTH-1:0] d,
  input  wire logic [WIDTH-1:0] tp,
  input  wire logic [WIDTH-1:0] ts,
  output mie_flags_t            flags,
  output logic      [WIDTH-1:0] rp_diff,
  output logic      [WIDTH-1:0] tp_sum
);

  // the one compare/subtract/add unit shared by every align and subtract step
  always_comb begin
    flags.fits = {d, 1'b0} <= {1'b0, rp};
    flags.ge   = d <= rp;
    rp_diff    = rp - d;
    tp_sum     = tp + ts;
  end

endmodule

`default_nettype wire

/* sv/modular_inverse_ext_euclid.sv */
`default_nettype none
// Channel   Ports                                   Handshake
// input     in_value, in_modulus                    start && !busy
// result    out_inverse, out_has_inverse            out_valid, one cycle, no stall
//
// One item at a time: busy stays high from acceptance until the cycle that strobes
// the result, and a new item may be accepted in that cycle. A division whose
// quotient has k+1 bits runs through the single shared unit: align, then
// compare/subtract, then rotate; one reduction, the remainder steps and a final
// step make an item, and a modulus below two goes straight to the final step.
// Reset (rst_n low, synchronous) returns to idle; the receiver cannot stall.

module modular_inverse_ext_euclid
  import mie_pkg::*;
#(
  parameter int WIDTH = MIE_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WIDTH-1:0] in_value,
  input  wire logic [WIDTH-1:0] in_modulus,
  output logic                  out_valid,
  output logic      [WIDTH-1:0] out_inverse,
  output logic                  out_has_inverse
);

  localparam int KW = $clog2(WIDTH);

  mie_state_t       state_r, state_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] rp_r, rp_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH-1:0] tp_r, tp_nxt;
  logic [WIDTH-1:0] t_r, t_nxt;
  logic [WIDTH-1:0] ts_r, ts_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             neg_r, neg_nxt;
  logic             reduce_r, reduce_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_inverse_r, out_inverse_nxt;
  logic             out_has_r, out_has_nxt;

  mie_flags_t       flags;
  logic [WIDTH-1:0] rp_diff;
  logic [WIDTH-1:0] tp_sum;
  logic [WIDTH-1:0] mag;
  logic [WIDTH-1:0] res;

  mie_unit #(
    .WIDTH(WIDTH)
  ) u_unit (
    .rp     (rp_r),
    .d      (d_r),
    .tp     (tp_r),
    .ts     (ts_r),
    .flags  (flags),
    .rp_diff(rp_diff),
    .tp_sum (tp_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r           <= m_nxt;
    rp_r          <= rp_nxt;
    r_r           <= r_nxt;
    d_r           <= d_nxt;
    tp_r          <= tp_nxt;
    t_r           <= t_nxt;
    ts_r          <= ts_nxt;
    k_r           <= k_nxt;
    neg_r         <= neg_nxt;
    reduce_r      <= reduce_nxt;
    out_inverse_r <= out_inverse_nxt;
    out_has_r     <= out_has_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    m_nxt           = m_r;
    rp_nxt          = rp_r;
    r_nxt           = r_r;
    d_nxt           = d_r;
    tp_nxt          = tp_r;
    t_nxt           = t_r;
    ts_nxt          = ts_r;
    k_nxt           = k_r;
    neg_nxt         = neg_r;
    reduce_nxt      = reduce_r;
    out_valid_nxt   = 1'b0;
    out_inverse_nxt = out_inverse_r;
    out_has_nxt     = out_has_r;

    mag = (tp_r >= m_r) ? tp_r - m_r : tp_r;
    res = (!neg_r && mag != '0) ? m_r - mag : mag;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // reduce the value modulo the modulus first
          m_nxt      = in_modulus;
          rp_nxt     = in_value;
          r_nxt      = in_modulus;
          d_nxt      = in_modulus;
          tp_nxt     = '0;
          t_nxt      = '0;
          ts_nxt     = '0;
          k_nxt      = '0;
          neg_nxt    = 1'b0;
          reduce_nxt = 1'b1;
          if (in_modulus < WIDTH'(2)) begin
            rp_nxt    = '0;
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        if (flags.fits) begin
          d_nxt  = {d_r[WIDTH-2:0], 1'b0};
          ts_nxt = {ts_r[WIDTH-2:0], 1'b0};
          k_nxt  = k_r + KW'(1);
        end else begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        if (flags.ge) begin
          rp_nxt = rp_diff;
          if (!reduce_r) begin
            tp_nxt = tp_sum;
          end
        end
        if (k_r == '0) begin
          state_nxt = ST_NEXT;
        end else begin
          d_nxt  = {1'b0, d_r[WIDTH-1:1]};
          ts_nxt = {1'b0, ts_r[WIDTH-1:1]};
          k_nxt  = k_r - KW'(1);
        end
      end
      ST_NEXT: begin
        if (reduce_r) begin
          reduce_nxt = 1'b0;
          if (rp_r == '0) begin
            state_nxt = ST_FINAL;
          end else begin
            rp_nxt    = m_r;
            r_nxt     = rp_r;
            d_nxt     = rp_r;
            tp_nxt    = '0;
            t_nxt     = WIDTH'(1);
            ts_nxt    = WIDTH'(1);
            state_nxt = ST_ALIGN;
          end
        end else begin
          // rotate remainders and coefficients, flip the sign
          rp_nxt  = r_r;
          r_nxt   = rp_r;
          d_nxt   = rp_r;
          tp_nxt  = t_r;
          t_nxt   = tp_r;
          ts_nxt  = tp_r;
          neg_nxt = !neg_r;
          if (rp_r == '0) begin
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_FINAL: begin
        out_valid_nxt = 1'b1;
        if (rp_r == WIDTH'(1) && res != '0) begin
          out_inverse_nxt = res;
          out_has_nxt     = 1'b1;
        end else begin
          out_inverse_nxt = '0;
          out_has_nxt     = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_inverse     = out_inverse_r;
  assign out_has_inverse = out_has_r;

`ifndef SYNTHESIS
  a_out_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FINAL))
    else $error("result strobe without a finished item");

  a_flag_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_inverse |-> out_inverse != '0 && out_inverse < m_r)
    else $error("inverse out of range");

  a_no_flag_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_inverse |-> out_inverse == '0)
    else $error("inverse nonzero without flag");

  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule

`default_nettype wire
